FILE: hdl/iad_pkg.sv
// ----------------------------------------------------------------------------
// iad_pkg
// Shared codes and constants of the interpolated allpass delay.
// ----------------------------------------------------------------------------
package iad_pkg;

    localparam int CFG_BITS  = 16;
    localparam int LEN_BITS  = 11;
    localparam int GAIN_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int GAIN_SHIFT = 14;
    localparam int GAIN_RND  = 8192;

    localparam logic CFG_SPM = 1'b0;
    localparam logic CFG_LEN = 1'b1;

    localparam logic ACT_PROCESS = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    localparam logic [CFG_BITS-1:0] SPM_RESET = 16'd12288;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1024;

endpackage

FILE: hdl/iad_ram.sv
// ----------------------------------------------------------------------------
// iad_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module iad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/interpolated_allpass_delay_top.sv
// ----------------------------------------------------------------------------
// interpolated_allpass_delay_top
// Allpass filter over a fractional delay line with linear interpolation.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | to block  | in_valid / in_ready  | action, sample_in, delay_ms,
//           |           |                      | gain
//   out     | from block| out_valid / out_ready| sample_out
//   cfg     | to block  | cfg_we               | cfg_index, cfg_data
//
// A sample item runs through S_MDLY, S_RPOS, S_RD0, S_RD1, S_INTP, S_YOUT,
// S_FB and S_WR from accept to the next accept, plus S_WR0 when the write
// head wraps at the guard slot; one multiplier serves all four products
// and the delay RAM gives one read per cycle. A clear item runs through
// the zero result state S_ZERO and a sweep of every RAM slot in S_CLEAR.
// After reset and after a length write taken while idle or sweeping, a sweep
// of every slot zeroes the RAM; in_ready stays low meanwhile.
// A stalled out channel holds the sequencer before the store write.
// ----------------------------------------------------------------------------
module interpolated_allpass_delay_top #(
    parameter int STORE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic [15:0]                         delay_ms,
    input  logic signed [iad_pkg::GAIN_BITS-1:0] gain,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [iad_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int MA  = (SB + 1 > 17) ? SB + 1 : 17;
    localparam int MB  = 17;
    localparam int PRW = MA + MB;
    localparam int YW  = SB + 4;
    localparam int DW  = (AW + 16 > 32) ? AW + 17 : 33;
    localparam int LW  = (AW + 1 > iad_pkg::LEN_BITS) ? AW + 1 : iad_pkg::LEN_BITS;
    localparam int FB  = iad_pkg::FRAC_BITS;
    localparam int GS  = iad_pkg::GAIN_SHIFT;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MDLY  = 4'd1;
    localparam logic [3:0] S_RPOS  = 4'd2;
    localparam logic [3:0] S_RD0   = 4'd3;
    localparam logic [3:0] S_RD1   = 4'd4;
    localparam logic [3:0] S_INTP  = 4'd5;
    localparam logic [3:0] S_YOUT  = 4'd6;
    localparam logic [3:0] S_FB    = 4'd7;
    localparam logic [3:0] S_WR    = 4'd8;
    localparam logic [3:0] S_WR0   = 4'd9;
    localparam logic [3:0] S_ZERO  = 4'd10;
    localparam logic [3:0] S_CLEAR = 4'd11;

    function automatic logic [AW-1:0] guard_of(input logic [iad_pkg::LEN_BITS-1:0] len);
        logic [LW-1:0] lw;
        lw = LW'(len);
        if (lw < LW'(2))
        begin
            lw = LW'(2);
        end
        if (lw > LW'(STORE_DEPTH))
        begin
            lw = LW'(STORE_DEPTH);
        end
        return AW'(lw - LW'(1));
    endfunction

    function automatic logic signed [SB-1:0] sat(input logic signed [YW-1:0] v);
        logic signed [SB-1:0] r;
        if ((&v[YW-1:SB-1]) || !(|v[YW-1:SB-1]))
        begin
            r = v[SB-1:0];
        end
        else if (v[YW-1])
        begin
            r = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SB-1){1'b1}}};
        end
        return r;
    endfunction

    logic [3:0]                   state_reg, state_next;
    logic [iad_pkg::CFG_BITS-1:0] spm_reg, spm_next;
    logic [AW-1:0]                guard_reg, guard_next;
    logic [AW-1:0]                wph_reg, wph_next;
    logic [AW-1:0]                clr_reg, clr_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [SB-1:0]         sample_out_reg, sample_out_next;

    logic signed [SB-1:0]         x_reg, x_next;
    logic signed [iad_pkg::GAIN_BITS-1:0] g_reg, g_next;
    logic [15:0]                  delay_reg, delay_next;
    logic signed [PRW-1:0]        prod_reg, prod_next;
    logic [AW-1:0]                ndx_reg, ndx_next;
    logic [FB-1:0]                frac_reg, frac_next;
    logic                         zero_reg, zero_next;
    logic signed [YW-1:0]         acc_reg, acc_next;
    logic signed [SB-1:0]         cur_reg, cur_next;
    logic signed [SB-1:0]         yq_reg, yq_next;
    logic signed [SB-1:0]         st_reg, st_next;

    logic signed [MA-1:0]         op_a;
    logic signed [MB-1:0]         op_b;
    logic signed [SB:0]           diff;
    logic signed [SB-1:0]         rdata_s;
    logic [SB-1:0]                rdata;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [SB-1:0]                ram_wdata;

    logic                         out_free;
    logic [AW-1:0]                wph_eff;
    logic [DW-1:0]                dsz, dszc, gfix, wfix, rph_a, rph;
    logic [AW-1:0]                rpi;
    logic signed [PRW:0]          nterm;
    logic signed [PRW-1:0]        fbsum;
    logic signed [YW-1:0]         ysum;
    logic signed [YW-1:0]         ssum;
    logic signed [SB-1:0]         st_val;

    iad_ram #(
        .WIDTH (SB),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign rdata_s  = $signed(rdata);
    assign out_free = !out_valid_reg || out_ready;
    assign wph_eff  = (wph_reg > guard_reg) ? guard_reg : wph_reg;
    assign diff     = (SB + 1)'(rdata_s) - (SB + 1)'(cur_reg);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_MDLY:
            begin
                op_a = MA'(spm_reg);
                op_b = MB'(delay_reg);
            end
            S_RPOS:
            begin
                op_a = MA'(x_reg);
                op_b = MB'(g_reg);
            end
            S_INTP:
            begin
                op_a = MA'(diff);
                op_b = MB'(frac_reg);
            end
            S_FB:
            begin
                op_a = MA'(yq_reg);
                op_b = MB'(g_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    assign dsz   = DW'(prod_reg[31:0]);
    assign gfix  = DW'({guard_reg, {FB{1'b0}}});
    assign wfix  = DW'({wph_eff, {FB{1'b0}}});
    assign dszc  = (dsz > gfix) ? gfix : dsz;
    assign rph_a = wfix - dszc;
    assign rph   = (wfix < dszc) ? rph_a + gfix : rph_a;
    assign rpi   = rph[AW+FB-1:FB];

    assign nterm  = -(PRW + 1)'(prod_reg) + (PRW + 1)'(iad_pkg::GAIN_RND);
    assign fbsum  = prod_reg + PRW'(iad_pkg::GAIN_RND);
    assign ysum   = acc_reg + YW'($signed(prod_reg[SB+FB:FB]));
    assign ssum   = YW'(x_reg) + YW'($signed(fbsum[SB+GS+2:GS]));
    assign st_val = sat(ssum);

    always_comb
    begin
        state_next      = state_reg;
        spm_next        = spm_reg;
        guard_next      = guard_reg;
        wph_next        = wph_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        sample_out_next = sample_out_reg;
        x_next          = x_reg;
        g_next          = g_reg;
        delay_next      = delay_reg;
        ndx_next        = ndx_reg;
        frac_next       = frac_reg;
        zero_next       = zero_reg;
        acc_next        = acc_reg;
        cur_next        = cur_reg;
        yq_next         = yq_reg;
        st_next         = st_reg;
        ram_we          = 1'b0;
        ram_waddr       = wph_eff;
        ram_wdata       = st_val;
        ram_raddr       = ndx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample_in;
                    g_next     = gain;
                    delay_next = delay_ms;
                    state_next = (action == iad_pkg::ACT_CLEAR) ? S_ZERO : S_MDLY;
                end
            end
            S_MDLY:
            begin
                state_next = S_RPOS;
            end
            S_RPOS:
            begin
                zero_next  = (dsz == '0);
                frac_next  = rph[FB-1:0];
                ndx_next   = (rpi >= guard_reg) ? guard_reg - AW'(1) : rpi;
                state_next = S_RD0;
            end
            S_RD0:
            begin
                acc_next   = YW'($signed(nterm[SB+GS+2:GS]));
                state_next = S_RD1;
            end
            S_RD1:
            begin
                ram_raddr  = ndx_reg + AW'(1);
                cur_next   = rdata_s;
                acc_next   = acc_reg + YW'(rdata_s);
                state_next = S_INTP;
            end
            S_INTP:
            begin
                state_next = S_YOUT;
            end
            S_YOUT:
            begin
                yq_next    = zero_reg ? x_reg : sat(ysum);
                state_next = S_FB;
            end
            S_FB:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = yq_reg;
                    state_next      = S_WR;
                end
            end
            S_WR:
            begin
                ram_we  = 1'b1;
                st_next = st_val;
                if (wph_eff == guard_reg)
                begin
                    state_next = S_WR0;
                end
                else
                begin
                    wph_next   = wph_eff + AW'(1);
                    state_next = S_IDLE;
                end
            end
            S_WR0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = st_reg;
                wph_next   = AW'(1);
                state_next = S_IDLE;
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = '0;
                    wph_next        = '0;
                    clr_next        = '0;
                    state_next      = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                iad_pkg::CFG_SPM:
                begin
                    spm_next = cfg_data;
                end
                iad_pkg::CFG_LEN:
                begin
                    guard_next = guard_of(cfg_data[iad_pkg::LEN_BITS-1:0]);
                    if (state_reg == S_IDLE || state_reg == S_CLEAR)
                    begin
                        wph_next   = '0;
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end
                end
                default:
                begin
                    spm_next = spm_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            spm_reg       <= iad_pkg::SPM_RESET;
            guard_reg     <= guard_of(iad_pkg::LEN_RESET);
            wph_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            spm_reg       <= spm_next;
            guard_reg     <= guard_next;
            wph_reg       <= wph_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_out_reg <= sample_out_next;
        x_reg          <= x_next;
        g_reg          <= g_next;
        delay_reg      <= delay_next;
        prod_reg       <= prod_next;
        ndx_reg        <= ndx_next;
        frac_reg       <= frac_next;
        zero_reg       <= zero_next;
        acc_reg        <= acc_next;
        cur_reg        <= cur_next;
        yq_reg         <= yq_next;
        st_reg         <= st_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    a_clear_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == iad_pkg::ACT_CLEAR) |=> state_reg == S_ZERO)
        else $error("clear item did not enter the zero result state");

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> wph_reg <= guard_reg)
        else $error("write head beyond guard slot while idle");

    a_sweep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (ram_we && ram_wdata == '0 && !in_ready))
        else $error("clear sweep not writing zeros");

    a_zero_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FB && zero_reg) |-> yq_reg == x_reg)
        else $error("zero delay result differs from input");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FB && out_free) |=> (out_valid && sample_out == $past(yq_reg)))
        else $error("result not loaded into output register");

endmodule

FILE: tb/sv/iad_checker.sv
// ----------------------------------------------------------------------------
// iad_checker
// Watches the sample, result and register channels of the interpolated
// allpass delay, keeps its own copy of the delay line and registers, works
// out each expected output sample and compares it with what the block sends.
// ----------------------------------------------------------------------------
module iad_checker import iad_pkg::*; #(
    parameter int STORE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           action,
    input  logic signed [SAMPLE_BITS-1:0]  sample_in,
    input  logic [15:0]                    delay_ms,
    input  logic signed [GAIN_BITS-1:0]    gain,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [SAMPLE_BITS-1:0]  sample_out,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [CFG_BITS-1:0]            cfg_data,
    output int                             mismatches,
    output int                             backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [SAMPLE_BITS-1:0] echo_line [STORE_DEPTH];
    longint                        head;
    logic [CFG_BITS-1:0]           rate_q88;
    logic [LEN_BITS-1:0]           line_len;
    logic signed [SAMPLE_BITS-1:0] expected_out [$];

    function automatic void wipe_line();
        for (int i = 0; i < STORE_DEPTH; i++)
            echo_line[i] = '0;
        head = 0;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input longint v);
        longint hi;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        if (v > hi)
            return hi[SAMPLE_BITS-1:0];
        if (v < -hi - 1)
            return ~hi[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] allpass_step(
        input logic                          act,
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic [15:0]                   dms,
        input logic signed [GAIN_BITS-1:0]   g
    );
        longint guard, wr, span, wrap, rd, tap, frac, cur, nxt, acc, xs, gs;
        logic signed [SAMPLE_BITS-1:0] y;
        if (act == ACT_CLEAR)
        begin
            wipe_line();
            return '0;
        end
        if (line_len < 2)
            guard = 1;
        else if (line_len > STORE_DEPTH)
            guard = STORE_DEPTH - 1;
        else
            guard = longint'(line_len) - 1;
        xs   = x;
        gs   = g;
        wr   = (head > guard) ? guard : head;
        span = longint'(rate_q88) * longint'(dms);
        acc  = xs;
        if (span > 0)
        begin
            wrap = guard <<< FRAC_BITS;
            if (span > wrap)
                span = wrap;
            rd = (wr <<< FRAC_BITS) - span;
            if (rd < 0)
                rd = rd + wrap;
            tap  = rd >>> FRAC_BITS;
            frac = rd - (tap <<< FRAC_BITS);
            if (tap >= guard)
                tap = guard - 1;
            cur = echo_line[tap];
            nxt = echo_line[tap + 1];
            acc = ((GAIN_RND - gs * xs) >>> GAIN_SHIFT) + cur
                + (((nxt - cur) * frac) >>> FRAC_BITS);
        end
        y   = clamp_sample(acc);
        acc = xs + ((gs * longint'(y) + GAIN_RND) >>> GAIN_SHIFT);
        echo_line[wr] = clamp_sample(acc);
        if (wr == guard)
        begin
            echo_line[0] = echo_line[wr];
            wr = 1;
        end
        else
            wr = wr + 1;
        head = wr % STORE_DEPTH;
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SAMPLE_BITS-1:0] want;
        if (!rst_n)
        begin
            wipe_line();
            rate_q88 = SPM_RESET;
            line_len = LEN_RESET;
            expected_out.delete();
            mismatches <= 0;
            backlog    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("%0t iad_checker: unexpected sample_out %0d, none pending",
                             $time, sample_out);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (sample_out !== want)
                    begin
                        $display("%0t iad_checker: sample_out expected %0d actual %0d",
                                 $time, want, sample_out);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_SPM)
                    rate_q88 = cfg_data;
                else
                begin
                    line_len = cfg_data[LEN_BITS-1:0];
                    wipe_line();
                end
            end
            if (in_valid && in_ready)
                expected_out.push_back(allpass_step(action, sample_in, delay_ms, gain));
            backlog <= expected_out.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the interpolated allpass delay with directed corner samples and
// phases of random samples under different register settings and idle
// patterns; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import iad_pkg::*;

    localparam int STORE_DEPTH     = 1024;
    localparam int SAMPLE_BITS     = 16;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 100;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic                          action    = ACT_PROCESS;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic [15:0]                   delay_ms  = '0;
    logic signed [GAIN_BITS-1:0]   gain      = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          cfg_we    = 1'b0;
    logic                          cfg_index = CFG_SPM;
    logic [CFG_BITS-1:0]           cfg_data  = '0;
    int                            mismatches;
    int                            backlog;
    int                            feed_idle_pct   = 0;
    int                            drain_stall_pct = 0;

    interpolated_allpass_delay_top #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sample_in  (sample_in),
        .delay_ms   (delay_ms),
        .gain       (gain),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    iad_checker #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .sample_in  (sample_in),
        .delay_ms   (delay_ms),
        .gain       (gain),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8ms;
        $display("tb: errors");
        $finish;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= drain_stall_pct);

    task automatic offer_item(
        input logic                          act,
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic [15:0]                   d,
        input logic signed [GAIN_BITS-1:0]   g
    );
        int gap;
        gap = 0;
        while (gap < 64 && $urandom_range(99) < feed_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        sample_in <= x;
        delay_ms  <= d;
        gain      <= g;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // wait out pending results, then a full clearing sweep
    task automatic settle();
        int waited;
        waited = 0;
        @(posedge clk);
        while (backlog != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (STORE_DEPTH + 32) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [CFG_BITS-1:0]           spm_plan [PHASES];
        logic [LEN_BITS-1:0]           len_plan [PHASES];
        longint                        guard_now;
        longint                        reach;
        int                            dsel;
        logic                          act;
        logic signed [SAMPLE_BITS-1:0] x;
        logic [15:0]                   d;
        logic signed [GAIN_BITS-1:0]   g;

        spm_plan = '{SPM_RESET, 16'hFFFF, 16'h0000, 16'd48,
                     SPM_RESET, 16'h0000, 16'h0100, 16'h0001};
        len_plan = '{LEN_RESET, 11'd1024, 11'd2, 11'd37,
                     11'd0, 11'd2047, 11'd3, 11'd2};
        spm_plan[5] = 16'($urandom);
        spm_plan[7] = 16'($urandom_range(1, 65535));
        len_plan[6] = 11'($urandom_range(3, 64));
        len_plan[7] = 11'($urandom_range(2, 1024));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        offer_item(ACT_PROCESS, 16'sd0, 16'd0, 16'sd0);
        offer_item(ACT_PROCESS, 16'sh7FFF, 16'd0, 16'sh7FFF);
        offer_item(ACT_PROCESS, 16'sh8000, 16'd0, 16'sh8000);
        offer_item(ACT_PROCESS, 16'sh7FFF, 16'h0001, 16'sh8000);
        offer_item(ACT_PROCESS, 16'sh8000, 16'h0002, 16'sh7FFF);
        offer_item(ACT_PROCESS, 16'sh7FFF, 16'hFFFF, 16'sh7FFF);
        offer_item(ACT_PROCESS, 16'sh8000, 16'hFFFF, 16'sh8000);
        offer_item(ACT_PROCESS, 16'sd12345, 16'h0100, 16'sd16384);
        offer_item(ACT_PROCESS, -16'sd12345, 16'h0015, -16'sd16384);
        offer_item(ACT_CLEAR, 16'shFFFF, 16'hFFFF, 16'shFFFF);
        offer_item(ACT_PROCESS, 16'sh5555, 16'h0003, 16'shAAAA);
        offer_item(ACT_PROCESS, 16'shAAAA, 16'h5555, 16'sh5555);
        offer_item(ACT_CLEAR, 16'sd0, 16'd0, 16'sd0);
        for (int k = 0; k < 10; k++)
            offer_item(ACT_PROCESS, (k % 2) ? 16'sh8000 : 16'sh7FFF,
                       16'(k + 4), 16'sh7FFF);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                write_reg(CFG_SPM, spm_plan[p]);
                write_reg(CFG_LEN, CFG_BITS'(len_plan[p]));
            end
            case (p % 4)
                0:
                begin
                    feed_idle_pct   = 0;
                    drain_stall_pct = 0;
                end
                1:
                begin
                    feed_idle_pct   = 86;
                    drain_stall_pct = 0;
                end
                2:
                begin
                    feed_idle_pct   = 0;
                    drain_stall_pct = 86;
                end
                default:
                begin
                    feed_idle_pct   = 17;
                    drain_stall_pct = 17;
                end
            endcase

            // keep most delays inside the active line so reads interpolate
            if (len_plan[p] < 2)
                guard_now = 1;
            else if (len_plan[p] > STORE_DEPTH)
                guard_now = STORE_DEPTH - 1;
            else
                guard_now = longint'(len_plan[p]) - 1;
            if (spm_plan[p] == 0)
                reach = 65535;
            else
                reach = (guard_now <<< 16) / longint'(spm_plan[p]) + 1;
            if (reach > 65535)
                reach = 65535;

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                act  = ($urandom_range(99) < 2) ? ACT_CLEAR : ACT_PROCESS;
                x    = ($urandom_range(1) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 16383) - 8192);
                dsel = $urandom_range(9);
                if (dsel == 0)
                    d = '0;
                else if (dsel < 3)
                    d = 16'($urandom);
                else
                    d = 16'($urandom_range(0, int'(reach)));
                g    = ($urandom_range(3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 32767) - 16384);
                offer_item(act, x, d, g);
            end
            in_valid <= 1'b0;
        end

        settle();
        if (mismatches == 0 && backlog == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
